// ===== rtl/core/bfa_pkg.sv =====
// bfa_pkg: shared types and codes of the bitmap frame allocator
// no dependencies; used by the interfaces, bfa_ctrl and bitmap_frame_allocator
package bfa_pkg;

   localparam int FRAME_W = 16;
   localparam int COUNT_W = 17;

   typedef enum logic [0:0] {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_ALLOCATED = 3'd0,
      ST_HELD      = 3'd1,
      ST_FREED     = 3'd2,
      ST_NOTHING   = 3'd3,
      ST_EXHAUSTED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FREE_RD,
      S_FREE_WR,
      S_SCAN,
      S_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               present_flag;
      logic               writable_flag;
      logic               user_flag;
      status_type         status;
   } result_type;

endpackage

// ===== rtl/core/bfa_req_if.sv =====
// bfa_req_if: request channel (valid/ready plus allocate/free payload)
// depends on bfa_pkg
interface bfa_req_if
   import bfa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [FRAME_W-1:0] current_frame;
   logic               kernel_only;
   logic               map_writable;

   modport source (output valid, kind, current_frame, kernel_only, map_writable, input ready);
   modport sink   (input valid, kind, current_frame, kernel_only, map_writable, output ready);
endinterface

// ===== rtl/core/bfa_rsp_if.sv =====
// bfa_rsp_if: response channel (valid/ready plus allocation result)
// depends on bfa_pkg
interface bfa_rsp_if
   import bfa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame_index;
   logic               present_flag;
   logic               writable_flag;
   logic               user_flag;
   status_type         status;

   modport source (output valid, frame_index, present_flag, writable_flag, user_flag, status,
                   input ready);
   modport sink   (input valid, frame_index, present_flag, writable_flag, user_flag, status,
                   output ready);
endinterface

// ===== rtl/core/bfa_csr_if.sv =====
// bfa_csr_if: configuration write channel carrying frame_count
// depends on bfa_pkg
interface bfa_csr_if
   import bfa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] frame_count;

   modport source (output valid, frame_count, input ready);
   modport sink   (input valid, frame_count, output ready);
endinterface

// ===== rtl/core/bfa_bitmap_ram.sv =====
// bfa_bitmap_ram: single write port, single read port bitmap memory
// registered read data; no dependencies
module bfa_bitmap_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32,
   parameter int AW    = 11
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bfa_ctrl.sv =====
// bfa_ctrl: sequencer for clear pass, first-fit word scan and free read-modify-write
// depends on bfa_pkg, bfa_req_if, bfa_rsp_if; drives bfa_bitmap_ram ports
module bfa_ctrl
   import bfa_pkg::*;
#(
   parameter int MAX_FRAMES = 65536,
   parameter int WORD_BITS  = 32,
   parameter int WORD_COUNT = 2048,
   parameter int AW         = 11,
   parameter int WCW        = 12,
   parameter int OFS        = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   bfa_req_if.sink              req_bus,
   bfa_rsp_if.source            rsp_bus,
   input  logic [WCW-1:0]       scan_words,
   output logic                 mem_wr_en,
   output logic [AW-1:0]        mem_wr_addr,
   output logic [WORD_BITS-1:0] mem_wr_data,
   output logic                 mem_rd_en,
   output logic [AW-1:0]        mem_rd_addr,
   input  logic [WORD_BITS-1:0] mem_rd_data
);

   localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

   function automatic logic [OFS-1:0] low_zero(input logic [WORD_BITS-1:0] w);
      logic [OFS-1:0] pos;
      pos = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (!w[j]) begin
            pos = OFS'(j);
         end
      end
      return pos;
   endfunction

   fsm_state_type state_ff, state_in;

   logic [AW-1:0]      clr_ff, clr_in;
   logic [WCW-1:0]     issue_ff, issue_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [AW-1:0]      chk_idx_ff, chk_idx_in;
   logic [FRAME_W-1:0] cur_ff, cur_in;
   logic               kern_ff, kern_in;
   logic               wr_ff, wr_in;
   result_type         res_ff, res_in;
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               req_fire;
   logic               out_free;
   logic               clr_last;
   logic               scan_more;
   logic               scan_hit;
   logic               free_range;
   logic [OFS-1:0]     hit_pos;
   logic [AW+OFS-1:0]  hit_frame;

   assign req_fire   = req_bus.valid && req_bus.ready;
   assign out_free   = !out_valid_ff || rsp_bus.ready;
   assign clr_last   = (clr_ff == AW'(WORD_COUNT - 1));
   assign scan_more  = (issue_ff < scan_words);
   assign scan_hit   = chk_valid_ff && (mem_rd_data != FULL_WORD);
   assign free_range = (32'(req_bus.current_frame) < 32'(MAX_FRAMES));
   assign hit_pos    = low_zero(mem_rd_data);
   assign hit_frame  = {chk_idx_ff, hit_pos};

   assign req_bus.ready = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               if (kind_type'(req_bus.kind) == KIND_ALLOC) begin
                  state_in = (req_bus.current_frame != '0) ? S_DONE : S_SCAN;
               end else begin
                  state_in = (req_bus.current_frame != '0 && free_range) ? S_FREE_RD : S_DONE;
               end
            end
         end
         S_FREE_RD: state_in = S_FREE_WR;
         S_FREE_WR: state_in = S_DONE;
         S_SCAN: begin
            if (scan_hit || (!chk_valid_ff && !scan_more)) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      clr_in       = clr_ff;
      issue_in     = issue_ff;
      chk_idx_in   = issue_ff[AW-1:0];
      chk_valid_in = 1'b0;
      cur_in       = cur_ff;
      kern_in      = kern_ff;
      wr_in        = wr_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = chk_idx_ff;
      mem_wr_data  = mem_rd_data | (WORD_BITS'(1) << hit_pos);
      mem_rd_en    = 1'b0;
      mem_rd_addr  = issue_ff[AW-1:0];

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
         end
         S_IDLE: begin
            issue_in = '0;
            if (req_fire) begin
               cur_in  = req_bus.current_frame;
               kern_in = req_bus.kernel_only;
               wr_in   = req_bus.map_writable;
               res_in  = '{frame_index: '0, present_flag: 1'b0, writable_flag: 1'b0,
                           user_flag: 1'b0, status: ST_FREED};
               if (kind_type'(req_bus.kind) == KIND_ALLOC) begin
                  res_in.frame_index = req_bus.current_frame;
                  res_in.status      = ST_HELD;
               end else if (req_bus.current_frame == '0) begin
                  res_in.status = ST_NOTHING;
               end
            end
         end
         S_FREE_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(cur_ff >> OFS);
         end
         S_FREE_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(cur_ff >> OFS);
            mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << cur_ff[OFS-1:0]);
         end
         S_SCAN: begin
            if (scan_hit) begin
               mem_wr_en = 1'b1;
               res_in    = '{frame_index: FRAME_W'(hit_frame), present_flag: 1'b1,
                             writable_flag: wr_ff, user_flag: !kern_ff,
                             status: ST_ALLOCATED};
            end else begin
               if (!chk_valid_ff && !scan_more) begin
                  res_in = '{frame_index: '0, present_flag: 1'b0, writable_flag: 1'b0,
                             user_flag: 1'b0, status: ST_EXHAUSTED};
               end
               if (scan_more) begin
                  mem_rd_en    = 1'b1;
                  chk_valid_in = 1'b1;
                  issue_in     = issue_ff + WCW'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= '0;
         chk_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      cur_ff     <= cur_in;
      kern_ff    <= kern_in;
      wr_ff      <= wr_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.frame_index   = out_ff.frame_index;
   assign rsp_bus.present_flag  = out_ff.present_flag;
   assign rsp_bus.writable_flag = out_ff.writable_flag;
   assign rsp_bus.user_flag     = out_ff.user_flag;
   assign rsp_bus.status        = out_ff.status;

endmodule

// ===== rtl/core/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: first-fit physical frame allocator, one bitmap bit per frame
// depends on bfa_pkg, bfa_req_if, bfa_rsp_if, bfa_csr_if, bfa_bitmap_ram, bfa_ctrl
//
//   channel   direction  carries
//   req_bus   in         kind, current_frame, kernel_only, map_writable
//   rsp_bus   out        frame_index, present_flag, writable_flag, user_flag, status
//   csr_bus   in         frame_count (always ready)
//
// reset starts a clearing pass over all MAX_FRAMES / WORD_BITS words (2048 by default),
// req_bus.ready stays low until it ends
// free: read the bitmap word, then write it back with the bit cleared; held / nothing
// to free: straight to result; allocation: read words until a clear bit or out of words
// one bitmap word read per cycle; a result not taken by rsp_bus stalls the next one
module bitmap_frame_allocator
   import bfa_pkg::*;
#(
   parameter int MAX_FRAMES = 65536,
   parameter int WORD_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   bfa_req_if.sink     req_bus,
   bfa_rsp_if.source   rsp_bus,
   bfa_csr_if.sink     csr_bus
);

   localparam int WORD_COUNT  = (MAX_FRAMES / WORD_BITS > 0) ? MAX_FRAMES / WORD_BITS : 1;
   localparam int AW          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int WCW         = AW + 1;
   localparam int OFS         = $clog2(WORD_BITS);
   localparam int RESET_LIMIT = (65536 > MAX_FRAMES) ? MAX_FRAMES : 65536;
   localparam int RESET_WORDS = RESET_LIMIT / WORD_BITS;

   logic [WCW-1:0]       words_ff, words_in;
   logic [31:0]          count_sat;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   assign csr_bus.ready = 1'b1;

   // saturate to the bitmap size, keep whole words only
   always_comb begin
      count_sat = (32'(csr_bus.frame_count) > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES)
                                                               : 32'(csr_bus.frame_count);
      words_in  = words_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         words_in = WCW'(count_sat >> OFS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= WCW'(RESET_WORDS);
      end else begin
         words_ff <= words_in;
      end
   end

   bfa_ctrl #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORD_BITS  (WORD_BITS),
      .WORD_COUNT (WORD_COUNT),
      .AW         (AW),
      .WCW        (WCW),
      .OFS        (OFS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .scan_words  (words_ff),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bfa_bitmap_ram #(
      .DEPTH (WORD_COUNT),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== tb/sv/bfa_result_checker.sv =====
`timescale 1ns / 100ps
// bfa_result_checker: watches the request, response and csr channels of the frame allocator
// keeps its own copy of the frame bitmap and frame count, predicts and compares each result
// depends on bfa_pkg, bfa_req_if, bfa_rsp_if, bfa_csr_if
module bfa_result_checker
   import bfa_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   bfa_req_if    req_mon,
   bfa_rsp_if    rsp_mon,
   bfa_csr_if    csr_mon,
   output int    fail_count,
   output int    pending_count
);

   localparam int MAP_WORDS  = 2048;
   localparam int WORD_W     = 32;
   localparam int MAP_FRAMES = MAP_WORDS * WORD_W;

   logic [WORD_W-1:0]  frame_map [MAP_WORDS];
   logic [COUNT_W-1:0] frame_limit;
   result_type         expected_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic result_type predict_result(kind_type kind, logic [FRAME_W-1:0] cur,
                                                 logic kern, logic wr);
      result_type         res;
      int unsigned        limit;
      int unsigned        words;
      logic               found;
      logic [FRAME_W-1:0] pick;
      res   = '0;
      found = 1'b0;
      pick  = '0;
      if (kind == KIND_ALLOC) begin
         if (cur != '0) begin
            res.frame_index = cur;
            res.status      = ST_HELD;
         end else begin
            limit = (frame_limit > MAP_FRAMES) ? MAP_FRAMES : frame_limit;
            words = limit / WORD_W;
            for (int i = 0; i < words && !found; i++) begin
               if (frame_map[i] != '1) begin
                  for (int j = 0; j < WORD_W && !found; j++) begin
                     if (!frame_map[i][j]) begin
                        found = 1'b1;
                        pick  = FRAME_W'(i * WORD_W + j);
                     end
                  end
               end
            end
            if (found) begin
               frame_map[pick[FRAME_W-1:5]][pick[4:0]] = 1'b1;
               res.frame_index   = pick;
               res.present_flag  = 1'b1;
               res.writable_flag = wr;
               res.user_flag     = ~kern;
               res.status        = ST_ALLOCATED;
            end else begin
               res.status = ST_EXHAUSTED;
            end
         end
      end else if (cur == '0) begin
         res.status = ST_NOTHING;
      end else begin
         frame_map[cur[FRAME_W-1:5]][cur[4:0]] = 1'b0;
         res.status = ST_FREED;
      end
      return res;
   endfunction

   function automatic void report_field(string field, int exp_value, int act_value);
      if (exp_value != act_value) begin
         $display("%0t mismatch on %s: expected %0d actual %0d",
                  $time, field, exp_value, act_value);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type exp;
      if (reset) begin
         for (int i = 0; i < MAP_WORDS; i++) frame_map[i] = '0;
         frame_limit = COUNT_W'(MAP_FRAMES);
         expected_results.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result: expected none actual frame %0d status %0d",
                        $time, rsp_mon.frame_index, rsp_mon.status);
               fail_count++;
            end else begin
               exp = expected_results.pop_front();
               report_field("frame_index", exp.frame_index, rsp_mon.frame_index);
               report_field("present_flag", exp.present_flag, rsp_mon.present_flag);
               report_field("writable_flag", exp.writable_flag, rsp_mon.writable_flag);
               report_field("user_flag", exp.user_flag, rsp_mon.user_flag);
               report_field("status", exp.status, rsp_mon.status);
            end
         end
         if (csr_mon.valid === 1'b1 && csr_mon.ready === 1'b1) begin
            frame_limit = csr_mon.frame_count;
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            expected_results.push_back(predict_result(kind_type'(req_mon.kind),
                                                      req_mon.current_frame,
                                                      req_mon.kernel_only,
                                                      req_mon.map_writable));
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== tb/sv/bitmap_frame_allocator_test.sv =====
`timescale 1ns / 100ps
// bitmap_frame_allocator_test: stimulus and verdict for the bitmap frame allocator
// drives allocate/free transactions and frame_count writes; checking is in bfa_result_checker
// depends on bfa_pkg, the channel interfaces, bitmap_frame_allocator and bfa_result_checker
module bitmap_frame_allocator_test;
   import bfa_pkg::*;

   localparam int RANDOM_ITEMS   = 550;
   localparam int PHASE_ITEMS    = 70;
   localparam int WATCHDOG_LIMIT = 25000;
   localparam int TAIL_CYCLES    = 2100;

   logic clock;
   logic reset;

   bfa_req_if req_bus ();
   bfa_rsp_if rsp_bus ();
   bfa_csr_if csr_bus ();

   int          fail_count;
   int          pending_count;
   int unsigned req_sent;
   int unsigned rsp_received;
   logic        req_burst;
   logic [FRAME_W-1:0] held_frames [$];

   bitmap_frame_allocator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bfa_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int draw_gap(logic burst);
      return burst ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic logic draw_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_request(input kind_type kind, input logic [FRAME_W-1:0] frame,
                               input logic kern, input logic wr);
      int gap;
      gap = draw_gap(req_burst);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= kind;
      req_bus.current_frame <= frame;
      req_bus.kernel_only   <= kern;
      req_bus.map_writable  <= wr;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      req_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (rsp_received < req_sent) @(negedge clock);
   endtask

   task automatic write_frame_count(input logic [COUNT_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.frame_count <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_random_item();
      int unsigned        pick;
      int unsigned        idx;
      logic [FRAME_W-1:0] frame;
      pick = $urandom_range(0, 99);
      if (pick < 3) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_request(KIND_ALLOC, '0, draw_bit(), draw_bit());
      end else if (pick < 75) begin
         if (held_frames.size() != 0) begin
            idx   = $urandom_range(0, held_frames.size() - 1);
            frame = held_frames[idx];
            held_frames.delete(idx);
         end else begin
            frame = FRAME_W'($urandom_range(0, 127));
         end
         send_request(KIND_FREE, frame, draw_bit(), draw_bit());
      end else if (pick < 85) begin
         if (held_frames.size() != 0) begin
            frame = held_frames[$urandom_range(0, held_frames.size() - 1)];
         end else begin
            frame = FRAME_W'($urandom_range(1, 65535));
         end
         send_request(KIND_ALLOC, frame, draw_bit(), draw_bit());
      end else begin
         send_request(kind_type'(draw_bit()), FRAME_W'($urandom_range(0, 65535)),
                      draw_bit(), draw_bit());
      end
   endtask

   function automatic logic [COUNT_W-1:0] draw_frame_count(int phase);
      int unsigned choice;
      choice = $urandom_range(0, 9);
      if (phase == 0 || choice == 0) return COUNT_W'(32);
      if (phase == 1 || choice == 1) return COUNT_W'(65536);
      if (phase == 2 || choice == 2) return '1;
      if (choice == 3) return COUNT_W'($urandom_range(0, 31));
      if (choice < 6) return COUNT_W'($urandom_range(32, 256));
      if (choice < 8) return COUNT_W'($urandom_range(257, 4096));
      return COUNT_W'($urandom_range(32, 65536));
   endfunction

   // response side: random backpressure, collects frames handed out
   initial begin : rsp_sink
      int          gap;
      int unsigned taken;
      logic        rsp_burst;
      rsp_bus.ready = 1'b0;
      taken         = 0;
      rsp_burst     = 1'b0;
      @(negedge clock);
      forever begin
         if (taken % 32 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         gap = draw_gap(rsp_burst);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (reset || rsp_bus.valid !== 1'b1) @(posedge clock);
         if (rsp_bus.status == ST_ALLOCATED) held_frames.push_back(rsp_bus.frame_index);
         rsp_received++;
         taken++;
         @(negedge clock);
      end
   end

   // watchdog on cycles without any accepted transaction
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("bitmap_frame_allocator regression: fail");
      $finish;
   end

   initial begin : stimulus
      int random_sent;
      int phase;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.kind          = KIND_ALLOC;
      req_bus.current_frame = '0;
      req_bus.kernel_only   = 1'b0;
      req_bus.map_writable  = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.frame_count   = '0;
      req_sent              = 0;
      rsp_received          = 0;
      req_burst             = 1'b0;
      random_sent           = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: flags, held pages, frame zero, free corners
      send_request(KIND_ALLOC, '0, 1'b0, 1'b1);
      send_request(KIND_ALLOC, '0, 1'b1, 1'b0);
      send_request(KIND_ALLOC, '0, 1'b1, 1'b1);
      send_request(KIND_ALLOC, 16'hFFFF, 1'b1, 1'b1);
      send_request(KIND_ALLOC, 16'd1, 1'b0, 1'b0);
      send_request(KIND_FREE, '0, 1'b0, 1'b0);
      send_request(KIND_FREE, 16'd1, 1'b1, 1'b1);
      wait_drained();
      send_request(KIND_ALLOC, '0, 1'b0, 1'b0);
      send_request(KIND_FREE, 16'hFFFF, 1'b0, 1'b0);

      // single word, free above the count, below one word, saturation
      write_frame_count(COUNT_W'(32));
      send_request(KIND_FREE, 16'd40, 1'b0, 1'b0);
      send_request(KIND_ALLOC, '0, 1'b1, 1'b0);
      write_frame_count(COUNT_W'(31));
      send_request(KIND_ALLOC, '0, 1'b0, 1'b1);
      write_frame_count('0);
      send_request(KIND_ALLOC, '0, 1'b0, 1'b0);
      send_request(KIND_FREE, 16'd2, 1'b0, 1'b0);
      write_frame_count('1);
      send_request(KIND_ALLOC, '0, 1'b1, 1'b1);

      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         write_frame_count(draw_frame_count(phase));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 24 == 0) req_burst = ($urandom_range(0, 3) == 0);
            send_random_item();
            random_sent++;
         end
         phase++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("bitmap_frame_allocator regression: pass");
      end else begin
         $display("bitmap_frame_allocator regression: fail");
      end
      $finish;
   end

endmodule

// ===== bitmap_frame_allocator.f =====
rtl/core/bfa_pkg.sv
rtl/core/bfa_req_if.sv
rtl/core/bfa_rsp_if.sv
rtl/core/bfa_csr_if.sv
rtl/core/bfa_bitmap_ram.sv
rtl/core/bfa_ctrl.sv
rtl/core/bitmap_frame_allocator.sv
tb/sv/bfa_result_checker.sv
tb/sv/bitmap_frame_allocator_test.sv
